[design/spq_pkg.sv]
`default_nettype none

package spq_pkg;

    // queue geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int TAG_BITS    = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // field widths fixed by the interface
    localparam int PRIO_W = 16;
    localparam int TAGIO_W = 16;
    localparam int OCC_W  = 5;

    // command codes
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    typedef struct packed {
        logic                     func;
        logic signed [PRIO_W-1:0] priority_req;
        logic [TAGIO_W-1:0]       tag;
    } t_in;

    typedef struct packed {
        logic                     is_empty;
        logic signed [PRIO_W-1:0] front_priority;
        logic [TAGIO_W-1:0]       front_tag;
        logic [OCC_W-1:0]         occupancy;
        logic                     rejected;
    } t_out;

    // one stored entry
    typedef struct packed {
        logic signed [PRIO_W-1:0] prio;
        logic [TAG_BITS-1:0]      tag;
    } t_entry;

    // command broadcast to every cell
    typedef struct packed {
        logic   ins;
        logic   rem;
        t_entry ent;
    } t_cell_ctl;

    // incoming tag into stored width; upper bits would be dropped, but both widths are 16 bits
    function automatic logic [TAG_BITS-1:0] tag_store(input logic [TAGIO_W-1:0] t);
        logic [TAG_BITS-1:0] r;
        r = '0;
        for (int b = 0; b < TAG_BITS; b++) begin
            if (b < TAGIO_W) begin
                r[b] = t[b];
            end
        end
        return r;
    endfunction

    // stored tag back to port width
    function automatic logic [TAGIO_W-1:0] tag_show(input logic [TAG_BITS-1:0] t);
        logic [TAGIO_W-1:0] r;
        r = '0;
        for (int b = 0; b < TAGIO_W; b++) begin
            if (b < TAG_BITS) begin
                r[b] = t[b];
            end
        end
        return r;
    endfunction

    // low bits of the count for the occupancy field
    function automatic logic [OCC_W-1:0] occ_show(input logic [CNT_W-1:0] c);
        logic [OCC_W-1:0] r;
        r = '0;
        for (int b = 0; b < OCC_W; b++) begin
            if (b < CNT_W) begin
                r[b] = c[b];
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[design/spq_cell.sv]
`default_nettype none

module spq_cell (
    input  wire                      i_clk,
    input  wire spq_pkg::t_cell_ctl  i_ctl,
    input  wire                      i_occ,
    input  wire                      i_left_keep,
    input  wire spq_pkg::t_entry     i_left_ent,
    input  wire spq_pkg::t_entry     i_right_ent,
    output spq_pkg::t_entry          o_ent,
    output spq_pkg::t_entry          o_next,
    output logic                     o_keep
);
    import spq_pkg::*;

    t_entry r_ent;
    t_entry n_ent;

    // entry stays in place when it is occupied and not after the new one
    assign o_keep = i_occ && (r_ent.prio <= i_ctl.ent.prio);

    // insert shifts right past the kept prefix, remove shifts left
    always_comb begin
        n_ent = r_ent;
        if (i_ctl.ins) begin
            if (o_keep) begin
                n_ent = r_ent;
            end else if (i_left_keep) begin
                n_ent = i_ctl.ent;
            end else begin
                n_ent = i_left_ent;
            end
        end else if (i_ctl.rem) begin
            n_ent = i_right_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

    assign o_ent  = r_ent;
    assign o_next = n_ent;

endmodule

`default_nettype wire

[design/sorted_priority_queue_core.sv]
`default_nettype none

// Sorted priority queue, a row of compare-and-shift cells.
// Command channel: i_cmd is taken at a rising edge with start high and busy
// low. func selects insert (priority_req, tag) or removal of the front entry.
// Entries are kept in ascending signed priority; an insert lands after every
// entry of equal or lower priority, so equal priorities leave in arrival order.
// Result channel: o_valid pulses for one cycle with o_res, the queue state
// after the command: front entry (zero when empty), empty flag, occupancy and
// a rejected flag for an insert into a full queue.
// Latency: the result appears the cycle after the command transfer.
// Throughput: one command per cycle; busy stays low. Every cell compares its
// own priority with the new one and shifts in the same cycle, so the update
// is one compare in depth whatever the queue size.
// Reset empties the queue by clearing the entry count; cell contents are not
// cleared. The receiver cannot stall; each result is taken in its cycle.
module sorted_priority_queue_core (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                start,
    output logic               busy,
    input  wire spq_pkg::t_in  i_cmd,
    output logic               o_valid,
    output spq_pkg::t_out      o_res
);
    import spq_pkg::*;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_valid;
    t_out             r_res;
    t_out             n_res;
    t_cell_ctl        w_ctl;
    logic             w_accept;
    logic             w_full;
    logic             w_reject;

    t_entry w_ent  [QUEUE_DEPTH];
    t_entry w_next [QUEUE_DEPTH];
    logic   w_keep [QUEUE_DEPTH];

    // command decode
    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_full   = (r_count == CNT_W'(QUEUE_DEPTH));
    assign w_reject = w_accept && (i_cmd.func == FUNC_INSERT) && w_full;

    always_comb begin
        w_ctl.ins      = w_accept && (i_cmd.func == FUNC_INSERT) && !w_full;
        w_ctl.rem      = w_accept && (i_cmd.func == FUNC_REMOVE) && (r_count != '0);
        w_ctl.ent.prio = i_cmd.priority_req;
        w_ctl.ent.tag  = tag_store(i_cmd.tag);
    end

    // cell row
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        spq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_occ       (CNT_W'(i) < r_count),
            .i_left_keep ((i == 0) ? 1'b1 : w_keep[(i == 0) ? 0 : i - 1]),
            .i_left_ent  (w_ent[(i == 0) ? 0 : i - 1]),
            .i_right_ent (w_ent[(i == QUEUE_DEPTH - 1) ? i : i + 1]),
            .o_ent       (w_ent[i]),
            .o_next      (w_next[i]),
            .o_keep      (w_keep[i])
        );
    end

    // entry count
    always_comb begin
        n_count = r_count;
        if (w_ctl.ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_ctl.rem) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // result from the state after this command
    always_comb begin
        n_res.is_empty       = (n_count == '0);
        n_res.front_priority = n_res.is_empty ? '0 : w_next[0].prio;
        n_res.front_tag      = n_res.is_empty ? '0 : tag_show(w_next[0].tag);
        n_res.occupancy      = occ_show(n_count);
        n_res.rejected       = w_reject;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_valid <= w_accept;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire

[design/spq_chk.sv]
`default_nettype none

module spq_chk (
    input wire                i_clk,
    input wire                i_rst_n,
    input wire                start,
    input wire                busy,
    input wire spq_pkg::t_in  i_cmd,
    input wire                o_valid,
    input wire spq_pkg::t_out o_res
);
    import spq_pkg::*;

    // every command transfer gives a result in the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_valid)
        else $error("no result after command transfer");

    // no result without a command
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |=> !o_valid)
        else $error("result without command transfer");

    // empty queue shows zero front and zero count
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.is_empty) |->
            (o_res.occupancy == '0 && o_res.front_priority == '0 && o_res.front_tag == '0))
        else $error("empty result with nonzero fields");

    // a rejection only comes from an insert into a full queue
    a_reject_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.rejected) |->
            ($past(i_cmd.func) == FUNC_INSERT && !o_res.is_empty))
        else $error("rejection not caused by insert into full queue");

endmodule

bind sorted_priority_queue_core spq_chk u_spq_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_cmd   (i_cmd),
    .o_valid (o_valid),
    .o_res   (o_res)
);

`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import spq_pkg::*;

    // one pending command, optionally held until the queue views drain
    typedef struct packed {
        logic drain;
        t_in  cmd;
    } t_pending;

    localparam int IDLE_LIMIT = 200;
    localparam int RAND_CMDS  = 500;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_in  i_cmd   = '0;
    logic busy;
    logic o_valid;
    t_out o_res;

    // predicted queue contents
    logic signed [PRIO_W-1:0] slot_prio [QUEUE_DEPTH];
    logic [TAG_BITS-1:0]      slot_tag  [QUEUE_DEPTH];
    int                       entry_cnt = 0;

    t_pending cmd_backlog [$];
    t_out     queue_views [$];
    logic     cmd_taken   = 1'b0;
    int       burst_left  = 8;
    int       gap_left    = 0;
    int       idle_cycles = 0;
    int       fail_cnt    = 0;

    sorted_priority_queue_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_cmd   (i_cmd),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // apply one command to the predicted queue, return the view after it
    function automatic t_out apply_queue_cmd(input t_in cmd);
        t_out view;
        int   pos;
        int   k;
        view = '0;
        if (cmd.func == FUNC_INSERT) begin
            if (entry_cnt >= QUEUE_DEPTH) begin
                view.rejected = 1'b1;
            end else begin
                // new entry goes after all entries of equal or lower priority
                pos = 0;
                while (pos < entry_cnt && $signed(slot_prio[pos]) <= $signed(cmd.priority_req))
                    pos++;
                for (k = entry_cnt; k > pos; k--) begin
                    slot_prio[k] = slot_prio[k-1];
                    slot_tag[k]  = slot_tag[k-1];
                end
                slot_prio[pos] = cmd.priority_req;
                slot_tag[pos]  = cmd.tag[TAG_BITS-1:0];
                entry_cnt++;
            end
        end else if (entry_cnt > 0) begin
            for (k = 1; k < entry_cnt; k++) begin
                slot_prio[k-1] = slot_prio[k];
                slot_tag[k-1]  = slot_tag[k];
            end
            entry_cnt--;
        end
        if (entry_cnt == 0) begin
            view.is_empty = 1'b1;
        end else begin
            view.front_priority = slot_prio[0];
            view.front_tag      = slot_tag[0];
        end
        view.occupancy = entry_cnt[OCC_W-1:0];
        return view;
    endfunction

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", fname, want, got);
            fail_cnt++;
        end
    endtask

    task automatic add_cmd(input logic func, input logic [PRIO_W-1:0] prio,
                           input logic [TAGIO_W-1:0] tg, input logic drain);
        t_pending p;
        p.drain             = drain;
        p.cmd.func          = func;
        p.cmd.priority_req  = prio;
        p.cmd.tag           = tg;
        cmd_backlog.push_back(p);
    endtask

    // command driver, bursts with random gaps
    always @(negedge i_clk) begin : drive_cmds
        logic go;
        go = 1'b0;
        if (i_rst_n) begin
            if (cmd_taken) begin
                void'(cmd_backlog.pop_front());
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            if (gap_left > 0) begin
                gap_left--;
            end else if (cmd_backlog.size() != 0 &&
                         !(cmd_backlog[0].drain && queue_views.size() != 0)) begin
                go = 1'b1;
            end
        end
        start <= go;
        if (go) begin
            i_cmd <= cmd_backlog[0].cmd;
        end
    end

    // result checker and command transfer tracking
    always @(posedge i_clk) begin : watch_results
        t_out want;
        if (!i_rst_n) begin
            cmd_taken <= 1'b0;
        end else begin
            if (o_valid) begin
                if (queue_views.size() == 0) begin
                    $error("result with no command outstanding");
                    fail_cnt++;
                end else begin
                    want = queue_views.pop_front();
                    check_field("is_empty", want.is_empty, o_res.is_empty);
                    check_field("front_priority", want.front_priority, o_res.front_priority);
                    check_field("front_tag", want.front_tag, o_res.front_tag);
                    check_field("occupancy", want.occupancy, o_res.occupancy);
                    check_field("rejected", want.rejected, o_res.rejected);
                end
            end
            if (start && !busy) begin
                queue_views.push_back(apply_queue_cmd(i_cmd));
            end
            cmd_taken <= start && !busy;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_valid) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb: failure");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin : stimulus
        int          n;
        int          i;
        int          seg_len;
        int          ins_pct;
        int          prio_mode;
        int          v;
        int unsigned r;
        logic        func;

        // directed: empty remove, extremes, ties, fill to full, overflow
        add_cmd(FUNC_REMOVE, 16'h1234, 16'hFFFF, 1'b0);
        add_cmd(FUNC_INSERT, 16'h7FFF, 16'hFFFF, 1'b0);
        add_cmd(FUNC_INSERT, 16'h8000, 16'h0000, 1'b0);
        add_cmd(FUNC_INSERT, 16'h0000, 16'h0001, 1'b0);
        add_cmd(FUNC_INSERT, 16'h0000, 16'h0002, 1'b0);
        add_cmd(FUNC_INSERT, 16'h0000, 16'h0003, 1'b0);
        add_cmd(FUNC_INSERT, 16'h7FFF, 16'h5555, 1'b0);
        add_cmd(FUNC_INSERT, 16'h8000, 16'hAAAA, 1'b0);
        for (i = 0; i < QUEUE_DEPTH - 7; i++) begin
            r = $urandom;
            add_cmd(FUNC_INSERT, r[31:16], r[15:0], 1'b0);
        end
        add_cmd(FUNC_INSERT, 16'h8000, 16'hBEEF, 1'b0);
        add_cmd(FUNC_REMOVE, 16'hFFFF, 16'h0000, 1'b0);
        add_cmd(FUNC_REMOVE, 16'h0000, 16'hFFFF, 1'b0);
        add_cmd(FUNC_REMOVE, 16'h5A5A, 16'hA5A5, 1'b0);
        add_cmd(FUNC_INSERT, 16'hFFFF, 16'h8001, 1'b0);

        // random segments biased to fill, to drain, or balanced
        n = 0;
        while (n < RAND_CMDS) begin
            seg_len = $urandom_range(8, 40);
            case ($urandom_range(0, 2))
                0: ins_pct = 80;
                1: ins_pct = 20;
                default: ins_pct = 50;
            endcase
            prio_mode = $urandom_range(0, 2);
            for (i = 0; i < seg_len; i++) begin
                func = ($urandom_range(0, 99) < ins_pct) ? FUNC_INSERT : FUNC_REMOVE;
                case (prio_mode)
                    // narrow range, many ties
                    0: v = (int'($urandom_range(0, 6)) - 3) * 256;
                    1: v = $urandom;
                    // near the extremes
                    default: v = ($urandom_range(0, 1) ? 32767 : -32768)
                                 + int'($urandom_range(0, 2)) - 1;
                endcase
                r = $urandom;
                add_cmd(func, v[PRIO_W-1:0], r[TAGIO_W-1:0],
                        (i == 0) && (n == 0 || $urandom_range(0, 5) == 0));
                n++;
            end
        end

        // reset
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // wait for all commands and results
        while (cmd_backlog.size() != 0) @(negedge i_clk);
        while (queue_views.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);

        if (fail_cnt == 0 && queue_views.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
